[design/lphs_pkg.sv]
// Shared types, codes and constants of the linear-probing hash set.
// Depends on nothing; every other file of the block imports it.
package lphs_pkg;

   localparam int TABLE_SIZE = 1021;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);

   localparam int KEY_W    = 32;
   localparam int ACT_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 10;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(340);

   // Home slot by reciprocal multiplication; the estimate of the quotient is exact
   // or one short, so one conditional subtract finishes the remainder.
   localparam int RECIP_SHIFT = 31 + SLOT_W;
   localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / TABLE_SIZE);

   // The queue between front and back; its depth must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_USED  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] home;
      logic              zero;
   } lphs_item_type;

   typedef struct packed {
      logic [CNT_W-1:0]    count;
      logic [STATUS_W-1:0] status;
      logic                found;
   } lphs_result_type;

endpackage

[design/lphs_front.sv]
// Front end of the hash set: takes a transaction, flags a zero key and works out
// the home slot. Depends on lphs_pkg.
module lphs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [lphs_pkg::ACT_W-1:0] in_action,
   input  logic [lphs_pkg::KEY_W-1:0] in_key,
   output logic                       push_valid,
   input  logic                       push_ready,
   output lphs_pkg::lphs_item_type    push_item
);
   import lphs_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_QUOT, F_MOD} state_type;

   state_type         state_ff;
   logic [ACT_W-1:0]  action_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [31:0]       mag_ff;
   logic [63:0]       prod_ff;
   logic [31:0]       qt_ff;
   logic [31:0]       mag_in;
   logic [SLOT_W:0]   rem_raw;
   logic [SLOT_W:0]   rem_fix;
   logic              accept;

   assign in_ready = (state_ff == F_IDLE);
   assign accept   = in_valid && in_ready;
   assign mag_in   = in_key[KEY_W-1] ? (~in_key + 32'd1) : in_key;

   // The true remainder is below twice the table size, so the low bits suffice.
   assign rem_raw = mag_ff[SLOT_W:0] - qt_ff[SLOT_W:0];
   assign rem_fix = (rem_raw >= (SLOT_W+1)'(TABLE_SIZE)) ?
                    rem_raw - (SLOT_W+1)'(TABLE_SIZE) : rem_raw;

   assign push_valid       = (state_ff == F_MOD);
   assign push_item.action = action_ff;
   assign push_item.key    = key_ff;
   assign push_item.home   = rem_fix[SLOT_W-1:0];
   assign push_item.zero   = (key_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  action_ff <= in_action;
                  key_ff    <= in_key;
                  mag_ff    <= mag_in;
                  state_ff  <= F_MUL;
               end
            end
            F_MUL: begin
               prod_ff  <= mag_ff * RECIP;
               state_ff <= F_QUOT;
            end
            F_QUOT: begin
               qt_ff    <= 32'(32'(prod_ff[63:RECIP_SHIFT]) * 32'(TABLE_SIZE));
               state_ff <= F_MOD;
            end
            F_MOD: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

[design/lphs_queue.sv]
// Short queue of classified transactions between the front and back ends.
// Depends on lphs_pkg.
module lphs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  lphs_pkg::lphs_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop,
   output lphs_pkg::lphs_item_type pop_item
);
   import lphs_pkg::*;

   lphs_item_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] fill_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

[design/lphs_back.sv]
// Back end of the hash set: slot tables, probe sequencer, element count and the
// result register, plus the clearing pass of the slot marks after reset.
// Depends on lphs_pkg.
module lphs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lphs_pkg::CNT_W-1:0] capacity,
   input  logic                       q_valid,
   output logic                       q_pop,
   input  lphs_pkg::lphs_item_type    q_item,
   output logic                       clearing,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lphs_pkg::lphs_result_type  rsp_result
);
   import lphs_pkg::*;

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_FINISH} state_type;

   logic [1:0]       mark_mem [TABLE_SIZE];
   logic [KEY_W-1:0] key_mem  [TABLE_SIZE];

   state_type         state_ff;
   lphs_item_type     item_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] n_ff;
   logic [SLOT_W-1:0] tomb_ff;
   logic              tomb_valid_ff;
   logic [SLOT_W-1:0] target_ff;
   logic              free_valid_ff;
   logic              found_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              rsp_valid_ff;
   lphs_result_type   rsp_ff;
   logic [1:0]        mark_rd_ff;
   logic [KEY_W-1:0]  key_rd_ff;

   logic [SLOT_W-1:0]   next_idx;
   logic [SLOT_W-1:0]   rd_addr;
   logic                hit_now;
   logic                empty_now;
   logic                tomb_now;
   logic                lap_end;
   logic                out_free;
   logic                fin;
   logic                add_new;
   logic                add_full;
   logic                add_ok;
   logic                rem_ok;
   logic [CNT_W-1:0]    count_next;
   logic [STATUS_W-1:0] status_next;
   logic                mark_we;
   logic [SLOT_W-1:0]   mark_waddr;
   logic [1:0]          mark_wdata;
   logic                key_we;

   assign next_idx  = (idx_ff == SLOT_LAST) ? '0 : idx_ff + 1'b1;
   assign q_pop     = (state_ff == B_IDLE) && q_valid;
   assign rd_addr   = (state_ff == B_IDLE) ? q_item.home : next_idx;
   assign hit_now   = (mark_rd_ff == MARK_USED) && (key_rd_ff == item_ff.key);
   assign empty_now = (mark_rd_ff == MARK_EMPTY);
   assign tomb_now  = !empty_now && (mark_rd_ff != MARK_USED);
   assign lap_end   = (n_ff == SLOT_LAST);
   assign clearing  = (state_ff == B_CLEAR);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fin      = (state_ff == B_FINISH) && out_free;
   assign add_new  = fin && !item_ff.zero && (item_ff.action == ACT_ADD) && !found_ff;
   assign add_full = add_new && ((count_ff >= capacity) || !free_valid_ff);
   assign add_ok   = add_new && !add_full;
   assign rem_ok   = fin && !item_ff.zero && (item_ff.action == ACT_REMOVE) && found_ff;

   always_comb begin
      count_next = count_ff;
      if (add_ok) begin
         count_next = count_ff + 1'b1;
      end else if (rem_ok && (count_ff != '0)) begin
         count_next = count_ff - 1'b1;
      end
   end

   always_comb begin
      priority if (item_ff.zero) begin
         status_next = ST_ZERO;
      end else if (add_full) begin
         status_next = ST_FULL;
      end else begin
         status_next = ST_DONE;
      end
   end

   always_comb begin
      mark_we    = 1'b0;
      mark_waddr = target_ff;
      mark_wdata = MARK_USED;
      key_we     = add_ok;
      priority if (state_ff == B_CLEAR) begin
         mark_we    = 1'b1;
         mark_waddr = idx_ff;
         mark_wdata = MARK_EMPTY;
      end else if (add_ok) begin
         mark_we = 1'b1;
      end else if (rem_ok) begin
         mark_we    = 1'b1;
         mark_wdata = MARK_TOMB;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_rd_ff <= mark_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[target_ff] <= item_ff.key;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         idx_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         tomb_valid_ff <= 1'b0;
         free_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         if (fin) begin
            rsp_valid_ff  <= 1'b1;
            rsp_ff.found  <= found_ff;
            rsp_ff.status <= status_next;
            rsp_ff.count  <= count_next;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            B_CLEAR: begin
               if (idx_ff == SLOT_LAST) begin
                  state_ff <= B_IDLE;
               end else begin
                  idx_ff <= next_idx;
               end
            end
            B_IDLE: begin
               if (q_valid) begin
                  item_ff       <= q_item;
                  idx_ff        <= q_item.home;
                  n_ff          <= '0;
                  tomb_valid_ff <= 1'b0;
                  free_valid_ff <= 1'b0;
                  found_ff      <= 1'b0;
                  state_ff      <= q_item.zero ? B_FINISH : B_PROBE;
               end
            end
            B_PROBE: begin
               if (empty_now) begin
                  target_ff     <= tomb_valid_ff ? tomb_ff : idx_ff;
                  free_valid_ff <= 1'b1;
                  state_ff      <= B_FINISH;
               end else if (hit_now) begin
                  found_ff  <= 1'b1;
                  target_ff <= idx_ff;
                  state_ff  <= B_FINISH;
               end else begin
                  if (tomb_now && !tomb_valid_ff) begin
                     tomb_ff       <= idx_ff;
                     tomb_valid_ff <= 1'b1;
                  end
                  if (lap_end) begin
                     target_ff     <= tomb_valid_ff ? tomb_ff : idx_ff;
                     free_valid_ff <= tomb_valid_ff || tomb_now;
                     state_ff      <= B_FINISH;
                  end else begin
                     idx_ff <= next_idx;
                     n_ff   <= n_ff + 1'b1;
                  end
               end
            end
            B_FINISH: begin
               if (out_free) begin
                  count_ff <= count_next;
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   // The element count moves by at most one per transaction.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + 1'b1) ||
                        (count_ff == $past(count_ff) - 1'b1))
      else $error("element count jumped by more than one");

   // Nothing leaves the queue while the marks are still being cleared.
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("queue popped during the clearing pass");

   // Keys are written only by a successful add in the finishing step.
   a_key_write: assert property (@(posedge clock) disable iff (reset)
      key_we |-> (state_ff == B_FINISH) && (item_ff.action == ACT_ADD) && !found_ff)
      else $error("slot key written outside an add");

   // A new result only appears after the finishing step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_FINISH))
      else $error("result raised without a finishing step");

endmodule

[design/linear_probe_hash_set_core.sv]
// Top level of the linear-probing hash set of nonzero 32-bit keys.
// Depends on lphs_pkg, lphs_front, lphs_queue and lphs_back.
//
// Usage. Each request transaction carries a key on req_tdata and an action on
// req_tuser (lookup, add or remove). Each one yields exactly one response
// transaction on rsp_tdata with the found flag, a status and the element count
// after the operation. The user writes the capacity register through csr_wen and
// csr_wdata only while idle, which the block does not enforce; it resets to 340.
//
// Operation. The front end takes no new request until it has worked out the home
// slot of the last one with two multiplications and the queue has taken it. The
// back end then probes one slot per cycle through the registered read of the
// slot tables. A two-entry queue lets the front end accept new requests while
// the back end is still probing.
//
// Reset is synchronous. Afterwards the back end clears all TABLE_SIZE (1021) slot
// marks, one slot per cycle; req_tready stays low throughout that pass while
// configuration writes are taken as usual. When the receiver holds rsp_tready
// low, the result stays in its register and the back end waits before finishing
// the next item; the front end and queue go on filling until the queue is full.
module linear_probe_hash_set_core (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,  // [31:0] key
   input  logic [1:0]                 req_tuser,  // [1:0] action
   // Response channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,  // [0] found, [2:1] status,
                                                  // [12:3] element_count, rest zero
   // Configuration port for the capacity limit.
   input  logic                       csr_wen,
   input  logic [lphs_pkg::CNT_W-1:0] csr_wdata
);
   import lphs_pkg::*;

   logic [CNT_W-1:0] capacity_ff;
   logic             front_ready;
   logic             clear_busy;
   logic             push_valid;
   logic             push_ready;
   lphs_item_type    push_item;
   logic             q_valid;
   logic             q_pop;
   lphs_item_type    q_item;
   lphs_result_type  result;

   // The capacity register is written at once; there is no read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wen) begin
         capacity_ff <= csr_wdata;
      end
   end

   // No request is taken until the clearing pass of the slot marks has ended.
   assign req_tready = front_ready && !clear_busy;

   lphs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid && !clear_busy),
      .in_ready   (front_ready),
      .in_action  (req_tuser),
      .in_key     (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   lphs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   lphs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .clearing   (clear_busy),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Fields packed from the lowest bit up, padded with zeros to two bytes.
   assign rsp_tdata = {3'b000, result.count, result.status, result.found};

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for linear_probe_hash_set_core, the linear-probing key set.
// Depends on lphs_pkg and the core; it keeps its own model of the slot table and
// compares every response transaction with it.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lphs_pkg::*;

   // Action code three is not named in the package; the block treats it as a lookup.
   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   localparam int POOL_SIZE      = 48;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [KEY_W-1:0] key;
   } set_request_type;

   typedef struct packed {
      logic                found;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    count;
   } set_outcome_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata = '0;
   logic [1:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [15:0]      rsp_tdata;
   logic             csr_wen = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   linear_probe_hash_set_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Our own copy of the slot table. It is advanced in the order in which request
   // transactions are accepted, which is also the order of the responses.
   logic [KEY_W-1:0] model_key  [TABLE_SIZE];
   logic [1:0]       model_mark [TABLE_SIZE];
   logic [CNT_W-1:0] model_count;
   logic [CNT_W-1:0] model_capacity;

   set_request_type  request_queue [$];
   set_outcome_type  expected_outcomes [$];
   logic [KEY_W-1:0] pool_keys [POOL_SIZE];

   int  mismatch_total = 0;
   int  quiet_cycles   = 0;
   bit  req_fired      = 1'b0;
   int  idle_odds      = 0;  // one chance in idle_odds of starting a gap; zero means none
   int  req_gap        = 0;
   int  rsp_gap        = 0;
   int  hold_asked     = 0;
   int  hold_served    = 0;
   int  hold_left      = 0;

   // Applies one operation to the model and returns the response it should produce.
   // The probe walks forward from the home slot, passing tombstones, until it meets
   // the key, an empty slot or has gone once round the whole table.
   function automatic set_outcome_type apply_set_op(input logic [ACT_W-1:0] action,
                                                    input logic [KEY_W-1:0] key);
      set_outcome_type  outcome;
      logic [KEY_W-1:0] magnitude;
      int               idx;
      int               tomb;
      int               hit;
      int               free_at;
      int               n;
      bit               stopped;
      outcome = '0;
      if (key == '0) begin
         outcome.status = ST_ZERO;
      end else begin
         // The most negative key negates to itself, which read unsigned is 2^31.
         magnitude = key[KEY_W-1] ? (~key + 1'b1) : key;
         idx       = int'(magnitude % KEY_W'(TABLE_SIZE));
         tomb      = TABLE_SIZE;
         hit       = TABLE_SIZE;
         free_at   = TABLE_SIZE;
         stopped   = 1'b0;
         for (n = 0; n < TABLE_SIZE && !stopped; n++) begin
            if (model_mark[idx] == MARK_EMPTY) begin
               free_at = (tomb < TABLE_SIZE) ? tomb : idx;
               stopped = 1'b1;
            end else if (model_mark[idx] == MARK_USED) begin
               if (model_key[idx] == key) begin
                  hit     = idx;
                  stopped = 1'b1;
               end
            end else if (tomb == TABLE_SIZE) begin
               tomb = idx;
            end
            if (!stopped) idx = (idx == TABLE_SIZE - 1) ? 0 : idx + 1;
         end
         // A full lap without an empty slot leaves only the first tombstone, if any.
         if (!stopped) free_at = tomb;
         outcome.found = (hit < TABLE_SIZE);
         if (action == ACT_ADD && !outcome.found) begin
            if (model_count >= model_capacity || free_at >= TABLE_SIZE) begin
               outcome.status = ST_FULL;
            end else begin
               model_key[free_at]  = key;
               model_mark[free_at] = MARK_USED;
               model_count++;
            end
         end else if (action == ACT_REMOVE && outcome.found) begin
            model_mark[hit] = MARK_TOMB;
            if (model_count > 0) model_count--;
         end
      end
      outcome.count = model_count;
      return outcome;
   endfunction

   // A nonzero key whose home is the given slot, of random size and sign.
   function automatic logic [KEY_W-1:0] shaped_key(input int home);
      logic [KEY_W-1:0] magnitude;
      magnitude = KEY_W'(home) + KEY_W'(TABLE_SIZE) * $urandom_range(1, 2_100_000);
      return $urandom_range(0, 1) ? (~magnitude + 1'b1) : magnitude;
   endfunction

   task automatic push_request(input logic [ACT_W-1:0] action, input logic [KEY_W-1:0] key);
      request_queue.push_back(set_request_type'{action, key});
   endtask

   // Waits until every queued request has been accepted and every response has come.
   task automatic wait_for_drain();
      do @(posedge clock);
      while (request_queue.size() != 0 || req_tvalid || expected_outcomes.size() != 0);
   endtask

   // The register is only written while the block is idle, so the model can take the
   // new limit straight away.
   task automatic write_capacity(input logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      model_capacity = value;
   endtask

   // Mostly keys from a small pool whose homes straddle the end of the table, so that
   // chains collide, wrap round and meet tombstones; the rest are random words or zero.
   task automatic run_random_phase(input int items);
      int               pick;
      logic [ACT_W-1:0] action;
      logic [KEY_W-1:0] key;
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      action = ACT_ADD;
         else if (pick < 70) action = ACT_LOOKUP;
         else if (pick < 97) action = ACT_REMOVE;
         else                action = ACT_SPARE;
         pick = $urandom_range(0, 99);
         if (pick < 75)      key = pool_keys[$urandom_range(0, POOL_SIZE - 1)];
         else if (pick < 97) key = $urandom();
         else                key = '0;
         push_request(action, key);
      end
   endtask

   // Request driver. A transaction stays on the bus until it is accepted; between
   // transactions the sender may pause at random for a gap of random length.
   always @(negedge clock) begin : request_driver
      set_request_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            req_gap    <= $urandom_range(0, 10);
            req_tvalid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            next_item  = request_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.key;
            req_tuser  <= next_item.action;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver. Besides the short bursts it serves each request for a long
   // hold-off, during which the block backs up and stops taking requests.
   always @(negedge clock) begin : response_receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES - 1;
         rsp_tready  <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_gap    <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: checks each response transaction against the oldest expectation, then
   // runs the model for a request transaction taken at the same edge. The response is
   // checked first so that a stray one is never paired with a brand-new expectation.
   always @(posedge clock) begin : handshake_monitor
      set_outcome_type want;
      bit              rsp_fired;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_tvalid && req_tready;
         rsp_fired = rsp_tvalid && rsp_tready;
         if (rsp_fired) begin
            if (expected_outcomes.size() == 0) begin
               $error("response with no request outstanding: tdata %h", rsp_tdata);
               mismatch_total++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_tdata[0] !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_tdata[0]);
                  mismatch_total++;
               end
               if (rsp_tdata[2:1] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[2:1]);
                  mismatch_total++;
               end
               if (rsp_tdata[12:3] !== want.count) begin
                  $error("element_count: expected %0d, actual %0d", want.count,
                         rsp_tdata[12:3]);
                  mismatch_total++;
               end
               if (rsp_tdata[15:13] !== 3'b000) begin
                  $error("padding: expected 0, actual %0d", rsp_tdata[15:13]);
                  mismatch_total++;
               end
            end
         end
         if (req_fired) expected_outcomes.push_back(apply_set_op(req_tuser, req_tdata));
         // Watchdog on cycles in which neither channel moves a transaction.
         quiet_cycles = (req_fired || rsp_fired) ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int               order [TABLE_SIZE];
      int               i;
      int               j;
      int               swap;
      logic [KEY_W-1:0] victim [$];
      for (i = 0; i < TABLE_SIZE; i++) model_mark[i] = MARK_EMPTY;
      model_count    = '0;
      model_capacity = CAP_RESET;
      for (i = 0; i < POOL_SIZE; i++) pool_keys[i] = shaped_key((1008 + i % 28) % TABLE_SIZE);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset limit. Requests wait out the clearing pass on
      // their own, since the block holds req_tready low until it is done.
      idle_odds = 6;
      push_request(ACT_LOOKUP, 32'h0000_0000);    // zero keys are ignored by every action
      push_request(ACT_ADD,    32'h0000_0000);
      push_request(ACT_REMOVE, 32'h0000_0000);
      push_request(ACT_SPARE,  32'd5);            // spare code acts as a lookup
      push_request(ACT_ADD,    32'd1);
      push_request(ACT_ADD,    32'd1);            // already present
      push_request(ACT_ADD,    32'hFFFF_FFFF);    // minus one shares the home of one
      push_request(ACT_ADD,    32'd1022);         // third key on the same chain
      push_request(ACT_REMOVE, 32'hFFFF_FFFF);    // leaves a tombstone mid-chain
      push_request(ACT_LOOKUP, 32'd1022);         // must probe past the tombstone
      push_request(ACT_ADD,    32'd2043);         // reuses that tombstone
      push_request(ACT_SPARE,  32'd1022);
      push_request(ACT_ADD,    32'h8000_0000);    // most negative key, magnitude 2^31
      push_request(ACT_LOOKUP, 32'h8000_0000);
      push_request(ACT_REMOVE, 32'h8000_0000);
      push_request(ACT_ADD,    32'h7FFF_FFFF);
      push_request(ACT_ADD,    32'd1020);         // last slot of the table
      push_request(ACT_ADD,    32'd2041);         // wraps round to slot zero
      push_request(ACT_ADD,    32'hFFFF_FC04);    // minus 1020, chain runs on past slot 3
      push_request(ACT_REMOVE, 32'd5);            // absent key
      push_request(ACT_LOOKUP, 32'hFFFF_FC04);
      wait_for_drain();

      // A limit of zero refuses every new key but still reports present ones.
      write_capacity(CNT_W'(0));
      push_request(ACT_ADD, 32'd77);
      push_request(ACT_ADD, 32'd1);
      wait_for_drain();
      write_capacity(CNT_W'(1));
      push_request(ACT_REMOVE, 32'd1);
      push_request(ACT_ADD,    32'd77);
      wait_for_drain();

      // Random part. The first phase also carries the long hold-off on the receiver.
      write_capacity(CAP_RESET);
      idle_odds = 4;
      run_random_phase(35);
      hold_asked++;
      wait_for_drain();

      write_capacity(CNT_W'(20));
      idle_odds = 0;
      run_random_phase(20);
      wait_for_drain();

      write_capacity(CNT_W'(5));
      idle_odds = 10;
      run_random_phase(15);
      wait_for_drain();

      write_capacity(CNT_W'(1021));
      idle_odds = 3;
      run_random_phase(15);
      wait_for_drain();

      // Last part, with no idling: fill every slot in shuffled order under the largest
      // limit, so that further new keys find the table itself full.
      idle_odds = 0;
      write_capacity(CNT_W'(1023));
      for (i = 0; i < TABLE_SIZE; i++) order[i] = i;
      for (i = TABLE_SIZE - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (i = 0; i < TABLE_SIZE; i++) push_request(ACT_ADD, shaped_key(order[i]));
      push_request(ACT_ADD,    shaped_key($urandom_range(0, TABLE_SIZE - 1)));
      push_request(ACT_LOOKUP, $urandom());
      wait_for_drain();

      write_capacity(CNT_W'(1022));
      push_request(ACT_ADD, shaped_key($urandom_range(0, TABLE_SIZE - 1)));
      wait_for_drain();

      // With the count at the limit the refusal now comes from the limit itself.
      write_capacity(CNT_W'(1021));
      push_request(ACT_ADD, shaped_key($urandom_range(0, TABLE_SIZE - 1)));
      wait_for_drain();

      // Punch a few holes in the full table and refill them through their tombstones.
      for (i = 0; i < 6; i++) victim.push_back(model_key[$urandom_range(0, TABLE_SIZE - 1)]);
      foreach (victim[n]) push_request(ACT_REMOVE, victim[n]);
      foreach (victim[n]) push_request(ACT_LOOKUP, victim[n]);
      for (i = 0; i < 4; i++) push_request(ACT_ADD, shaped_key($urandom_range(0, TABLE_SIZE - 1)));
      push_request(ACT_ADD, victim[0]);
      wait_for_drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && expected_outcomes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[filelist.f]
design/lphs_pkg.sv
design/lphs_front.sv
design/lphs_queue.sv
design/lphs_back.sv
design/linear_probe_hash_set_core.sv
tb/sv/testbench.sv
